>>> src/dnsar_pkg.sv
// Shared types, constants and reply byte builder for the DNS A-record responder.
// No dependencies.
`default_nettype none
package dnsar_pkg;

	localparam int ENTRIES_DEF      = 8;
	localparam int NAME_BYTES_DEF   = 256;
	localparam int PACKET_BYTES_DEF = 512;
	localparam int QUEUE_DEPTH      = 4;
	localparam int HDR_BYTES        = 12;

	localparam logic [1:0] CMD_NAME  = 2'd0;
	localparam logic [1:0] CMD_ENTRY = 2'd1;
	localparam logic [1:0] CMD_PKT   = 2'd2;

	localparam logic [7:0] FLAGS_HI = 8'h81;
	localparam logic [7:0] FLAGS_LO = 8'h80;
	localparam logic [7:0] PTR_HI   = 8'hC0;
	localparam logic [7:0] PTR_LO   = 8'h0C;
	localparam logic [7:0] TTL_LO   = 8'h2C;
	localparam logic [7:0] RD_LEN   = 8'h04;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam logic [4:0] HDR_LAST_STEP = 5'(HDR_BYTES - 1);
	localparam logic [4:0] ANS_LAST_STEP = 5'd16;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN,
		PH_BODY,
		PH_TAIL,
		PH_DROP
	} phase_t;

	typedef enum logic [1:0] {
		FS_RUN,
		FS_LOOK,
		FS_EMIT
	} front_state_t;

	typedef enum logic [1:0] {
		JOB_ECHO,
		JOB_HEADER,
		JOB_ANSWER,
		JOB_ABORT
	} job_kind_t;

	// One queued reply job; addr carries the ID for a header job.
	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  data;
		logic [31:0] addr;
	} job_t;

	function automatic logic [4:0] job_last_step(job_kind_t k);
		logic [4:0] r;
		case (k)
			JOB_HEADER: r = HDR_LAST_STEP;
			JOB_ANSWER: r = ANS_LAST_STEP;
			default:    r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] job_byte(job_t j, logic [4:0] step);
		logic [7:0] r;
		r = 8'h00;
		case (j.kind)
			JOB_ECHO: r = j.data;
			JOB_HEADER: begin
				case (step)
					5'd0:    r = j.addr[15:8];
					5'd1:    r = j.addr[7:0];
					5'd2:    r = FLAGS_HI;
					5'd3:    r = FLAGS_LO;
					5'd5:    r = 8'h01;
					5'd7:    r = 8'h01;
					default: r = 8'h00;
				endcase
			end
			JOB_ANSWER: begin
				case (step)
					5'd0:    r = j.data;
					5'd1:    r = PTR_HI;
					5'd2:    r = PTR_LO;
					5'd4:    r = 8'h01;
					5'd6:    r = 8'h01;
					5'd9:    r = 8'h01;
					5'd10:   r = TTL_LO;
					5'd12:   r = RD_LEN;
					5'd13:   r = j.addr[31:24];
					5'd14:   r = j.addr[23:16];
					5'd15:   r = j.addr[15:8];
					5'd16:   r = j.addr[7:0];
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/dnsar_fifo.sv
// Short job queue between the parser front and the reply back end.
// Depends on dnsar_pkg.
`default_nettype none
module dnsar_fifo
	import dnsar_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head_job,
	output logic      full,
	output logic      empty
);
	localparam int AW = $clog2(QUEUE_DEPTH);

	job_t          mem_q [QUEUE_DEPTH];
	logic [AW:0]   wr_q;
	logic [AW:0]   rd_q;

	assign empty    = (wr_q == rd_q);
	assign full     = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
	assign head_job = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[AW-1:0]] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> src/dnsar_back.sv
// Reply back end: expands queued jobs into reply bytes behind an output register.
// Depends on dnsar_pkg.
`default_nettype none
module dnsar_back
	import dnsar_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head_job,
	input  wire logic empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] reply_byte,
	output logic      reply_last,
	output logic      aborted
);
	logic [4:0] step_q;
	logic       adv;
	logic       at_last;

	assign adv     = !out_valid || !out_stall;
	assign at_last = (step_q == job_last_step(head_job.kind));
	assign pop     = adv && !empty && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			step_q    <= '0;
		end else if (adv) begin
			out_valid <= !empty;
			if (!empty) begin
				step_q <= at_last ? 5'd0 : step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !empty) begin
			reply_byte <= job_byte(head_job, step_q);
			reply_last <= (head_job.kind == JOB_ABORT) ||
				((head_job.kind == JOB_ANSWER) && at_last);
			aborted    <= (head_job.kind == JOB_ABORT);
		end
	end
endmodule
`default_nettype wire

>>> src/dnsar_front.sv
// Front end: table writes, query parsing, name capture and table lookup.
// Depends on dnsar_pkg.
`default_nettype none
module dnsar_front
	import dnsar_pkg::*;
#(
	parameter int ENTRIES      = ENTRIES_DEF,
	parameter int NAME_BYTES   = NAME_BYTES_DEF,
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [2:0]  entry,
	input  wire logic [7:0]  name_offset,
	input  wire logic [7:0]  data_byte,
	input  wire logic [31:0] ipv4_address,
	input  wire logic [7:0]  name_length,
	input  wire logic        entry_valid,
	input  wire logic        packet_end,
	input  wire logic        q_full,
	output logic             push,
	output job_t             push_job
);
	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NA = $clog2(NAME_BYTES);
	localparam int CW = $clog2(NAME_BYTES + 1);
	localparam int PW = $clog2(PACKET_BYTES + 1);

	// table
	logic [31:0]        addr_q    [ENTRIES];
	logic [7:0]         len_q     [ENTRIES];
	logic [ENTRIES-1:0] usable_q;
	logic [7:0]         name_rd_q [ENTRIES];

	// query name store
	logic [7:0] qn_mem_q [NAME_BYTES];
	logic [7:0] qn_rd_q;

	// parser
	front_state_t state_q, n_state;
	phase_t       phase_q, n_phase;
	logic [PW-1:0] pcnt_q, n_pcnt;
	logic [7:0]   label_q, n_label;
	logic [CW-1:0] qcnt_q, n_qcnt;
	logic         over_q, n_over;
	logic [2:0]   tail_q, n_tail;
	logic [15:0]  id_q, n_id;
	logic [7:0]   qdhi_q, n_qdhi;

	// lookup
	logic [CW-1:0]      look_len_q;
	logic               look_over_q;
	logic [7:0]         echo_q;
	logic [ENTRIES-1:0] cand_q;
	logic [CW-1:0]      k_q;
	logic               cmp_s1;

	logic       accept, pkt_acc, go_look, qn_we, done, stop;
	logic [7:0] qn_wd;
	logic [2:0] t_inc;
	logic [31:0] hit_addr;

	assign accept  = in_valid && !in_stall;
	assign pkt_acc = accept && (command == CMD_PKT);
	assign in_stall = (state_q != FS_RUN) || q_full;

	always_comb begin
		hit_addr = 32'd0;
		for (int e = ENTRIES - 1; e >= 0; e--) begin
			if (cand_q[e]) begin
				hit_addr = addr_q[e];
			end
		end
		if (look_over_q) begin
			hit_addr = 32'd0;
		end
	end

	always_comb begin
		n_state  = state_q;
		n_phase  = phase_q;
		n_pcnt   = pcnt_q;
		n_label  = label_q;
		n_qcnt   = qcnt_q;
		n_over   = over_q;
		n_tail   = tail_q;
		n_id     = id_q;
		n_qdhi   = qdhi_q;
		push     = 1'b0;
		push_job = '0;
		qn_we    = 1'b0;
		qn_wd    = data_byte;
		done     = 1'b0;
		go_look  = 1'b0;
		stop     = 1'b0;
		t_inc    = tail_q + 3'd1;
		case (state_q)
			FS_RUN: begin
				if (pkt_acc) begin
					if (pcnt_q < PW'(PACKET_BYTES)) begin
						n_pcnt = pcnt_q + 1'b1;
					end
					stop = packet_end || (pcnt_q >= PW'(PACKET_BYTES - 1));
					push_job.data = data_byte;
					push_job.kind = JOB_ECHO;
					case (phase_q)
						PH_HEADER: begin
							if (pcnt_q == PW'(0)) n_id[15:8] = data_byte;
							if (pcnt_q == PW'(1)) n_id[7:0] = data_byte;
							if (pcnt_q == PW'(4)) n_qdhi = data_byte;
							if (pcnt_q == PW'(5) && {qdhi_q, data_byte} != 16'd1) begin
								n_phase = PH_DROP;
							end
							if (pcnt_q == PW'(HDR_BYTES - 1)) begin
								push          = 1'b1;
								push_job.kind = JOB_HEADER;
								push_job.addr = {16'd0, id_q};
								n_phase       = PH_LEN;
							end
						end
						PH_LEN: begin
							push = 1'b1;
							if (data_byte == 8'd0) begin
								n_tail  = 3'd0;
								n_phase = PH_TAIL;
							end else begin
								if (qcnt_q != '0 || over_q) begin
									qn_wd = DOT_CHAR;
									if (qcnt_q < CW'(NAME_BYTES)) begin
										qn_we  = 1'b1;
										n_qcnt = qcnt_q + 1'b1;
									end else begin
										n_over = 1'b1;
									end
								end
								n_label = data_byte;
								n_phase = PH_BODY;
							end
						end
						PH_BODY: begin
							push = 1'b1;
							if (qcnt_q < CW'(NAME_BYTES)) begin
								qn_we  = 1'b1;
								n_qcnt = qcnt_q + 1'b1;
							end else begin
								n_over = 1'b1;
							end
							if (label_q != 8'd0) begin
								n_label = label_q - 8'd1;
							end
							if (label_q <= 8'd1) begin
								n_phase = PH_LEN;
							end
						end
						PH_TAIL: begin
							n_tail = t_inc;
							if (t_inc >= 3'd4) begin
								done    = 1'b1;
								go_look = 1'b1;
								n_phase = PH_DROP;
								n_state = FS_LOOK;
							end else begin
								push = 1'b1;
							end
						end
						default: n_phase = PH_DROP;
					endcase
					if (stop && !done && n_phase != PH_DROP) begin
						push          = 1'b1;
						push_job      = '0;
						push_job.kind = JOB_ABORT;
						n_phase       = PH_DROP;
					end
					if (packet_end) begin
						n_pcnt  = '0;
						n_phase = PH_HEADER;
						n_label = 8'd0;
						n_qcnt  = '0;
						n_over  = 1'b0;
						n_tail  = 3'd0;
					end
				end
			end
			FS_LOOK: begin
				if (k_q >= look_len_q && !cmp_s1) begin
					n_state = FS_EMIT;
				end
			end
			FS_EMIT: begin
				if (!q_full) begin
					push          = 1'b1;
					push_job.kind = JOB_ANSWER;
					push_job.data = echo_q;
					push_job.addr = hit_addr;
					n_state       = FS_RUN;
				end
			end
			default: n_state = FS_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FS_RUN;
			phase_q  <= PH_HEADER;
			pcnt_q   <= '0;
			label_q  <= '0;
			qcnt_q   <= '0;
			over_q   <= 1'b0;
			tail_q   <= '0;
			id_q     <= '0;
			qdhi_q   <= '0;
			usable_q <= '0;
			cmp_s1   <= 1'b0;
			k_q      <= '0;
		end else begin
			state_q <= n_state;
			phase_q <= n_phase;
			pcnt_q  <= n_pcnt;
			label_q <= n_label;
			qcnt_q  <= n_qcnt;
			over_q  <= n_over;
			tail_q  <= n_tail;
			id_q    <= n_id;
			qdhi_q  <= n_qdhi;
			if (accept && command == CMD_ENTRY && 32'(entry) < ENTRIES) begin
				usable_q[EW'(entry)] <= entry_valid;
			end
			if (go_look) begin
				k_q    <= '0;
				cmp_s1 <= 1'b0;
			end else if (state_q == FS_LOOK) begin
				cmp_s1 <= (k_q < look_len_q);
				if (k_q < look_len_q) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	// table entry fields and lookup bookkeeping
	always_ff @(posedge clk) begin
		if (accept && command == CMD_ENTRY && 32'(entry) < ENTRIES) begin
			addr_q[EW'(entry)] <= ipv4_address;
			len_q[EW'(entry)]  <= name_length;
		end
		if (go_look) begin
			look_len_q  <= qcnt_q;
			look_over_q <= over_q;
			echo_q      <= data_byte;
			for (int e = 0; e < ENTRIES; e++) begin
				cand_q[e] <= usable_q[e] && (32'(len_q[e]) <= NAME_BYTES) &&
					(32'(len_q[e]) == 32'(qcnt_q));
			end
		end else if (cmp_s1) begin
			for (int e = 0; e < ENTRIES; e++) begin
				if (name_rd_q[e] != qn_rd_q) begin
					cand_q[e] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qn_we) begin
			qn_mem_q[qcnt_q[NA-1:0]] <= qn_wd;
		end
		qn_rd_q <= qn_mem_q[k_q[NA-1:0]];
	end

	// one name store per entry, read in step at the compare index
	for (genvar g = 0; g < ENTRIES; g++) begin : g_name
		logic [7:0] name_mem_q [NAME_BYTES];
		always_ff @(posedge clk) begin
			if (accept && command == CMD_NAME && 32'(entry) == g &&
				32'(name_offset) < NAME_BYTES) begin
				name_mem_q[NA'(name_offset)] <= data_byte;
			end
			name_rd_q[g] <= name_mem_q[k_q[NA-1:0]];
		end
	end
endmodule
`default_nettype wire

>>> src/dns_a_record_responder.sv
// Top level of the DNS A-record responder.
// Depends on dnsar_pkg, dnsar_front, dnsar_fifo, dnsar_back.
`default_nettype none
// Takes a DNS query one byte per word (command 2) and streams back a reply
// word by word; commands 0 and 1 load the name table and take effect at once.
// A query with question count 1 gets a reply header after its 12th byte, an
// echo of every question byte, and an A answer (C00C, type 1, class 1,
// TTL 300, length 4, address) with the last QCLASS byte. The address is the
// one of the first usable entry whose stored dotted name equals the decoded
// QNAME, else 0.0.0.0. A query that ends before its question is complete
// gives one word with aborted and reply_last set.
// Timing: input words are taken one per cycle while the job queue has room
// and no lookup runs. The last QCLASS byte starts the lookup, which compares
// all entries in parallel one name byte per cycle; input is stalled until the
// answer job is queued. The back end sends one reply word per cycle from its
// output register while out_stall is low, and the four-deep queue lets the
// front keep parsing meanwhile.
module dns_a_record_responder
	import dnsar_pkg::*;
#(
	parameter int ENTRIES      = ENTRIES_DEF,
	parameter int NAME_BYTES   = NAME_BYTES_DEF,
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [2:0]  entry,
	input  wire logic [7:0]  name_offset,
	input  wire logic [7:0]  data_byte,
	input  wire logic [31:0] ipv4_address,
	input  wire logic [7:0]  name_length,
	input  wire logic        entry_valid,
	input  wire logic        packet_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       reply_byte,
	output logic             reply_last,
	output logic             aborted
);
	logic q_full, q_empty, q_push, q_pop;
	job_t q_in, q_head;

	dnsar_front #(
		.ENTRIES(ENTRIES),
		.NAME_BYTES(NAME_BYTES),
		.PACKET_BYTES(PACKET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.entry(entry),
		.name_offset(name_offset),
		.data_byte(data_byte),
		.ipv4_address(ipv4_address),
		.name_length(name_length),
		.entry_valid(entry_valid),
		.packet_end(packet_end),
		.q_full(q_full),
		.push(q_push),
		.push_job(q_in)
	);

	// jobs: echo, header, answer, abort
	dnsar_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(q_in),
		.pop(q_pop),
		.head_job(q_head),
		.full(q_full),
		.empty(q_empty)
	);

	dnsar_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_job(q_head),
		.empty(q_empty),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reply_byte(reply_byte),
		.reply_last(reply_last),
		.aborted(aborted)
	);
endmodule
`default_nettype wire
